### design/stack_bytecode_interpreter_defines.svh
// Assertion macros for the stack bytecode interpreter.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef STACK_BYTECODE_INTERPRETER_DEFINES_SVH
`define STACK_BYTECODE_INTERPRETER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SBI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sbi_pkg.sv
// Shared types and constants of the stack bytecode interpreter.
// No dependencies; imported by sbi_stack and the top level.
package sbi_pkg;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_HALT  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    localparam logic [2:0] CFG_OPCODE_PUSH = 3'd0;
    localparam logic [2:0] CFG_OPCODE_ADD  = 3'd1;
    localparam logic [2:0] CFG_OPCODE_EMIT = 3'd2;
    localparam logic [2:0] CFG_OPCODE_HALT = 3'd3;
    localparam logic [2:0] CFG_OPCODE_NOP  = 3'd4;

    localparam logic [7:0] RST_OPCODE_PUSH = 8'd1;
    localparam logic [7:0] RST_OPCODE_ADD  = 8'd2;
    localparam logic [7:0] RST_OPCODE_EMIT = 8'd3;
    localparam logic [7:0] RST_OPCODE_HALT = 8'd255;
    localparam logic [7:0] RST_OPCODE_NOP  = 8'd0;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_PUSH,
        PEND_EMIT,
        PEND_HALT
    } pend_t;

    typedef enum logic [1:0] {
        STK_NONE,
        STK_PUSH,
        STK_POP,
        STK_ADD
    } stack_op_t;

    typedef struct packed {
        stack_op_t   op;
        logic        clear;
        logic [31:0] data;
    } stack_cmd_t;

endpackage

### design/sbi_stack.sv
// Value stack with the top two entries in registers and the rest in a memory.
// Depends on sbi_pkg for the command struct.
module sbi_stack
    import sbi_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  stack_cmd_t                         cmd,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   count,
    output logic [31:0]                        top
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [31:0]   mem [STACK_DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   top_reg, sec_reg, third_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [CW-1:0] wr_addr_full, rd_addr_full;

    always_comb begin
        count_next = count_reg;
        case (cmd.op)
            STK_PUSH: count_next = count_reg + CW'(1);
            STK_POP:  count_next = count_reg - CW'(1);
            STK_ADD:  count_next = count_reg - CW'(1);
            default:  count_next = count_reg;
        endcase
        if (cmd.clear) begin
            count_next = '0;
        end
    end

    // Spill the second entry on push; prefetch the third entry for the next cycle.
    assign wr_en        = (cmd.op == STK_PUSH) && (count_reg >= CW'(2));
    assign wr_addr_full = count_reg - CW'(2);
    assign rd_addr_full = count_next - CW'(3);
    assign wr_addr      = wr_addr_full[AW-1:0];
    assign rd_addr      = rd_addr_full[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= sec_reg;
        end
        if (count_next >= CW'(3)) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                third_reg <= sec_reg;
            end else begin
                third_reg <= mem[rd_addr];
            end
        end
        case (cmd.op)
            STK_PUSH: begin
                top_reg <= cmd.data;
                sec_reg <= top_reg;
            end
            STK_POP: begin
                top_reg <= sec_reg;
                sec_reg <= third_reg;
            end
            STK_ADD: begin
                top_reg <= top_reg + sec_reg;
                sec_reg <= third_reg;
            end
            default: begin
                top_reg <= top_reg;
            end
        endcase
    end

    assign count = count_reg;
    assign top   = top_reg;

endmodule

### design/stack_bytecode_interpreter.sv
// Stack bytecode interpreter: decode and output stage, one tape byte per cycle while s_ready is high.
// Depends on sbi_pkg, sbi_stack and stack_bytecode_interpreter_defines.svh.
//
// Usage:
//   The s_ channel carries one tape byte per request, with s_last_byte marking
//   the end of a tape. The m_ channel carries at most one result per byte:
//   an emitted event, a halt code or a fault. Opcode values are written through
//   cfg_wr_en / cfg_index / cfg_wr_data while the block is idle.
//   A result is registered and appears on m_ in the cycle after its byte.
//   Throughput: one byte per cycle while s_ready is high; the stack keeps its top
//   two entries in registers and prefetches the third from a simple dual-port
//   memory, so each byte needs one memory write and one registered read at most.
//   The output register accepts a new byte while its result is being taken;
//   if m_ready stays low with a result held, s_ready drops until it is taken.
//   Reset (aresetn low, synchronous) empties the stack, restores the default
//   opcodes and leaves the block running and awaiting an opcode. The last byte
//   of every tape does the same, apart from the opcodes.
`include "stack_bytecode_interpreter_defines.svh"

module stack_bytecode_interpreter
    import sbi_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_tape_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [15:0] m_event_id,
    output logic [31:0] m_event_value,
    output logic [7:0]  m_halt_code
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]    op_push_reg, op_add_reg, op_emit_reg, op_halt_reg, op_nop_reg;
    logic          run_reg, run_next;
    pend_t         pend_reg, pend_next;
    logic [2:0]    seen_reg, seen_next;
    logic [31:0]   acc_reg, acc_next, acc_full;
    logic [1:0]    pos;
    logic          op_done;

    logic          m_valid_reg;
    logic [1:0]    kind_reg, kind_next;
    logic [15:0]   id_reg, id_next;
    logic [31:0]   value_reg, value_next;
    logic [7:0]    code_reg, code_next;
    logic          fire;

    logic          accept;
    stack_cmd_t    stk_cmd;
    logic [CW-1:0] stack_count;
    logic [31:0]   stack_top;

    sbi_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .count   (stack_count),
        .top     (stack_top)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Merge the incoming byte into its little-endian lane of the operand.
    assign pos = seen_reg[1:0];
    always_comb begin
        case (pos)
            2'd0:    acc_full = acc_reg | {24'd0, s_tape_byte};
            2'd1:    acc_full = acc_reg | {16'd0, s_tape_byte, 8'd0};
            2'd2:    acc_full = acc_reg | {8'd0, s_tape_byte, 16'd0};
            default: acc_full = acc_reg | {s_tape_byte, 24'd0};
        endcase
    end

    always_comb begin
        case (pend_reg)
            PEND_PUSH: op_done = (pos == 2'd3);
            PEND_EMIT: op_done = (pos == 2'd1);
            default:   op_done = 1'b1;
        endcase
    end

    always_comb begin
        run_next      = run_reg;
        pend_next     = pend_reg;
        seen_next     = seen_reg;
        acc_next      = acc_reg;
        stk_cmd.op    = STK_NONE;
        stk_cmd.clear = 1'b0;
        stk_cmd.data  = acc_full;
        fire          = 1'b0;
        kind_next     = KIND_FAULT;
        id_next       = '0;
        value_next    = '0;
        code_next     = '0;

        if (accept && run_reg) begin
            if (pend_reg == PEND_NONE) begin
                seen_next = '0;
                acc_next  = '0;
                // First match wins when opcodes share a value.
                if (s_tape_byte == op_push_reg) begin
                    if (s_last_byte || (stack_count >= CW'(STACK_DEPTH))) begin
                        fire = 1'b1;
                    end else begin
                        pend_next = PEND_PUSH;
                    end
                end else if (s_tape_byte == op_add_reg) begin
                    if (stack_count < CW'(2)) begin
                        fire = 1'b1;
                    end else begin
                        stk_cmd.op = STK_ADD;
                    end
                end else if (s_tape_byte == op_emit_reg) begin
                    if (s_last_byte || (stack_count == '0)) begin
                        fire = 1'b1;
                    end else begin
                        pend_next = PEND_EMIT;
                    end
                end else if (s_tape_byte == op_halt_reg) begin
                    if (s_last_byte) begin
                        fire = 1'b1;
                    end else begin
                        pend_next = PEND_HALT;
                    end
                end else if (s_tape_byte != op_nop_reg) begin
                    fire = 1'b1;
                end
                if (fire) begin
                    run_next  = 1'b0;
                    pend_next = PEND_NONE;
                    seen_next = seen_reg;
                    acc_next  = acc_reg;
                end
            end else if (!op_done) begin
                seen_next = {1'b0, pos} + 3'd1;
                acc_next  = acc_full;
                if (s_last_byte) begin
                    fire      = 1'b1;
                    run_next  = 1'b0;
                    pend_next = PEND_NONE;
                end
            end else begin
                pend_next = PEND_NONE;
                seen_next = '0;
                acc_next  = '0;
                case (pend_reg)
                    PEND_PUSH: begin
                        stk_cmd.op = STK_PUSH;
                    end
                    PEND_EMIT: begin
                        stk_cmd.op = STK_POP;
                        fire       = 1'b1;
                        kind_next  = KIND_EVENT;
                        id_next    = acc_full[15:0];
                        value_next = stack_top;
                    end
                    default: begin
                        fire      = 1'b1;
                        run_next  = 1'b0;
                        kind_next = KIND_HALT;
                        code_next = acc_full[7:0];
                    end
                endcase
            end
        end

        // End of tape: start the next tape from a clean machine.
        if (accept && s_last_byte) begin
            run_next      = 1'b1;
            pend_next     = PEND_NONE;
            seen_next     = '0;
            acc_next      = '0;
            stk_cmd.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_push_reg <= RST_OPCODE_PUSH;
            op_add_reg  <= RST_OPCODE_ADD;
            op_emit_reg <= RST_OPCODE_EMIT;
            op_halt_reg <= RST_OPCODE_HALT;
            op_nop_reg  <= RST_OPCODE_NOP;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OPCODE_PUSH: op_push_reg <= cfg_wr_data;
                CFG_OPCODE_ADD:  op_add_reg  <= cfg_wr_data;
                CFG_OPCODE_EMIT: op_emit_reg <= cfg_wr_data;
                CFG_OPCODE_HALT: op_halt_reg <= cfg_wr_data;
                CFG_OPCODE_NOP:  op_nop_reg  <= cfg_wr_data;
                default:         op_nop_reg  <= op_nop_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b1;
            pend_reg    <= PEND_NONE;
            seen_reg    <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            pend_reg <= pend_next;
            seen_reg <= seen_next;
            acc_reg  <= acc_next;
            if (accept && fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until a new result replaces it.
    always_ff @(posedge aclk) begin
        if (accept && fire) begin
            kind_reg  <= kind_next;
            id_reg    <= id_next;
            value_reg <= value_next;
            code_reg  <= code_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_event_id    = id_reg;
    assign m_event_value = value_reg;
    assign m_halt_code   = code_reg;

    `SBI_ASSERT_NOW(a_count_bound, 1'b1, stack_count <= CW'(STACK_DEPTH), "stack count beyond depth")
    `SBI_ASSERT_NEXT(a_tape_end_clears, accept && s_last_byte, (stack_count == '0) && run_reg && (pend_reg == PEND_NONE), "tape end did not re-initialize")
    `SBI_ASSERT_NEXT(a_stopped_silent, accept && !run_reg, !m_valid, "result produced while stopped")

endmodule
